>>> src/x86de_pkg.sv
// ----------------------------------------------------------------------------
// x86de_pkg: shared types and constants for the x86 subset decoder/executor
// front classifies code bytes into operations, back runs them on the regfile
// ----------------------------------------------------------------------------
package x86de_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int NUM_REGS    = 8;
  localparam int RIDX_W      = $clog2(NUM_REGS);
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);

  // configuration register indexes
  localparam logic [1:0] CFG_ENTRY = 2'd0;
  localparam logic [1:0] CFG_LIMIT = 2'd1;
  localparam logic [1:0] CFG_SYS   = 2'd2;

  // input actions
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  // result kinds
  localparam logic [2:0] K_EXEC   = 3'd0;
  localparam logic [2:0] K_DONE   = 3'd1;
  localparam logic [2:0] K_TRUNC  = 3'd2;
  localparam logic [2:0] K_UNSUP  = 3'd3;
  localparam logic [2:0] K_DENIED = 3'd4;
  localparam logic [2:0] K_LIMIT  = 3'd5;
  localparam logic [2:0] K_READ   = 3'd6;

  // opcode bytes
  localparam logic [7:0] OPC_NOP   = 8'h90;
  localparam logic [7:0] OPC_RET   = 8'hc3;
  localparam logic [7:0] OPC_ESC   = 8'h0f;
  localparam logic [7:0] OPC_SYS   = 8'h05;
  localparam logic [7:0] OPC_REXW  = 8'h48;
  localparam logic [7:0] OPC_MOVI0 = 8'hb8;
  localparam logic [7:0] OPC_MOVI7 = 8'hbf;
  localparam logic [7:0] OPC_MOVR  = 8'h89;
  localparam logic [7:0] OPC_ADDR  = 8'h01;
  localparam logic [7:0] OPC_MOVS  = 8'hc7;

  typedef enum logic [2:0] {
    PH_FIRST, PH_0F, PH_REX, PH_MODRM, PH_IMM
  } phase_t;

  // back-end operations
  typedef enum logic [3:0] {
    OP_NOP,      // executed without register write
    OP_RET,
    OP_SYS,
    OP_MOV,
    OP_ADD,
    OP_IMM,
    OP_STOP,     // single stop result (trunc/unsup/limit/denied) with given kind
    OP_READ,
    OP_WRITE
  } op_t;

  // one queued command from front to back
  typedef struct packed {
    op_t                 op;
    logic [2:0]          kind;      // for OP_STOP
    logic                last;      // code buffer ends after this instr
    logic                at_limit;  // step count reaches limit after this instr
    logic [63:0]         addr;      // rip or fault address
    logic [31:0]         count;     // executed count reported
    logic [RIDX_W-1:0]   dst;
    logic [RIDX_W-1:0]   src;
    logic [63:0]         value;
  } cmd_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [63:0]       address;
    logic [31:0]       executed_count;
    logic              wrote_register;
    logic [RIDX_W-1:0] dest_index;
    logic [63:0]       dest_value;
    logic              was_syscall;
    logic              last_of_run;
  } res_t;

endpackage

>>> src/x86_subset_decode_execute.sv
// ----------------------------------------------------------------------------
// x86_subset_decode_execute: byte-serial x86-64 subset decoder and executor
//
// channel | dir | beat contents
// in_     | in  | tdata: action, code_byte, reg_index, reg_value; tlast: is_last
// out_    | out | tdata: kind, address, executed_count, wrote_register,
//         |     |        dest_index, dest_value, was_syscall; tlast: last_of_run
// cfg_    | in  | index 0 entry_address, 1 step_limit, 2 syscalls_allowed
//
// one beat per cycle into decoder unless queue full; 4-entry queue feeds executor
// instruction ending with a tail result yields two results from the executor
// synchronous active-low reset; registers zeroed, step_limit 1024
// input stalls only when the command queue is full
// ----------------------------------------------------------------------------
module x86_subset_decode_execute import x86de_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [79:0]  in_tdata,  // action, code_byte, reg_index, reg_value, pad
  input  logic         in_tlast,  // is_last
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [167:0] out_tdata, // kind, address, executed_count, wrote_register,
                                  // dest_index, dest_value, was_syscall
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_wdata
);

  logic [63:0] entry_r;
  logic [31:0] limit_r;
  logic        sys_r;
  logic        q_wv, q_wr, q_rv, q_rr;
  cmd_t        q_wd, q_rd;
  res_t        res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
      limit_r <= 32'd1024;
      sys_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENTRY: entry_r <= cfg_wdata;
        CFG_LIMIT: limit_r <= cfg_wdata[31:0];
        CFG_SYS:   sys_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  x86de_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .action(in_tdata[1:0]), .code_byte(in_tdata[9:2]), .is_last(in_tlast),
    .reg_index(in_tdata[12:10]), .reg_value(in_tdata[76:13]),
    .entry_address(entry_r), .step_limit(limit_r), .syscalls_allowed(sys_r),
    .cmd_valid(q_wv), .cmd_ready(q_wr), .cmd(q_wd)
  );

  x86de_queue u_queue (
    .clk, .rst_n,
    .wr_valid(q_wv), .wr_ready(q_wr), .wr_data(q_wd),
    .rd_valid(q_rv), .rd_ready(q_rr), .rd_data(q_rd)
  );

  x86de_back u_back (
    .clk, .rst_n,
    .cmd_valid(q_rv), .cmd_ready(q_rr), .cmd(q_rd),
    .res_valid(out_tvalid), .res_ready(out_tready), .res
  );

  assign out_tdata = {res.was_syscall, res.dest_value, res.dest_index,
                      res.wrote_register, res.executed_count, res.address, res.kind};
  assign out_tlast = res.last_of_run;

endmodule

>>> src/x86de_front.sv
// ----------------------------------------------------------------------------
// x86de_front: byte decoder
// tracks decode phase, offsets and step count; emits at most one command per beat
// ----------------------------------------------------------------------------
module x86de_front import x86de_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  code_byte,
  input  logic        is_last,
  input  logic [RIDX_W-1:0] reg_index,
  input  logic [63:0] reg_value,
  input  logic [63:0] entry_address,
  input  logic [31:0] step_limit,
  input  logic        syscalls_allowed,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  logic                   running_r, running_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [OFFSET_BITS-1:0] ofs_r, ofs_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [31:0]            cnt_r, cnt_nxt;
  logic [7:0]             opc_r, opc_nxt;
  logic [7:0]             modrm_r, modrm_nxt;
  logic [63:0]            imm_r, imm_nxt;
  logic [3:0]             need_r, need_nxt;

  logic                   fire;
  logic [OFFSET_BITS-1:0] ofs_inc;
  logic [63:0]            fault, rip;
  logic [31:0]            cnt_inc;
  logic [3:0]             total;
  logic [3:0]             need_eff;
  logic [2:0]             bsel;
  logic [63:0]            imm_or;

  assign in_ready = cmd_ready;
  assign fire     = in_valid && in_ready;
  assign ofs_inc  = ofs_r + 1'b1;
  assign fault    = entry_address + 64'(start_r);
  assign rip      = entry_address + 64'(ofs_inc);
  assign cnt_inc  = cnt_r + 32'd1;
  assign total    = (opc_r == OPC_MOVS) ? 4'd4 : 4'd8;
  assign need_eff = (need_r == 4'd0 || need_r > total) ? total : need_r;
  assign bsel     = 3'(total - need_eff);
  assign imm_or   = imm_r | (64'(code_byte) << {bsel, 3'b000});

  // decode and command build
  always_comb begin
    running_nxt = running_r;
    phase_nxt   = phase_r;
    ofs_nxt     = ofs_r;
    start_nxt   = start_r;
    cnt_nxt     = cnt_r;
    opc_nxt     = opc_r;
    modrm_nxt   = modrm_r;
    imm_nxt     = imm_r;
    need_nxt    = need_r;
    cmd_valid   = 1'b0;
    cmd         = '0;
    cmd.op      = OP_NOP;
    cmd.last    = is_last;
    cmd.count   = cnt_r;
    cmd.addr    = fault;
    if (fire) begin
      unique case (action)
        ACT_START: begin
          ofs_nxt = '0; start_nxt = '0; cnt_nxt = '0;
          opc_nxt = '0; modrm_nxt = '0; imm_nxt = '0;
          phase_nxt = PH_FIRST; need_nxt = '0;
          running_nxt = 1'b1;
          if (step_limit == 32'd0) begin
            running_nxt = 1'b0;
            cmd_valid = 1'b1;
            cmd.op    = OP_STOP;
            cmd.kind  = K_LIMIT;
            cmd.addr  = entry_address;
            cmd.count = '0;
          end
        end
        ACT_WRITE: begin
          cmd_valid = 1'b1;
          cmd.op    = OP_WRITE;
          cmd.dst   = reg_index;
          cmd.value = reg_value;
        end
        ACT_READ: begin
          cmd_valid = 1'b1;
          cmd.op    = OP_READ;
          cmd.dst   = reg_index;
        end
        default: begin
          if (running_r) begin
            if (phase_r == PH_FIRST && cnt_r >= step_limit) begin
              cmd_valid = 1'b1;
              cmd.op    = OP_STOP;
              cmd.kind  = K_LIMIT;
              running_nxt = 1'b0;
              need_nxt  = '0;
            end else begin
              logic done, unsup;
              done  = 1'b0;
              unsup = 1'b0;
              ofs_nxt = ofs_inc;
              unique case (phase_r)
                PH_FIRST: begin
                  if (code_byte == OPC_NOP) begin
                    done = 1'b1; cmd.op = OP_NOP;
                  end else if (code_byte == OPC_RET) begin
                    done = 1'b1; cmd.op = OP_RET;
                  end else if (code_byte == OPC_ESC) begin
                    phase_nxt = PH_0F;
                  end else if (code_byte == OPC_REXW) begin
                    phase_nxt = PH_REX;
                  end else begin
                    unsup = 1'b1;
                  end
                end
                PH_0F: begin
                  if (code_byte == OPC_SYS) begin
                    done = 1'b1;
                    cmd.op = syscalls_allowed ? OP_SYS : OP_RET;
                    if (!syscalls_allowed) begin
                      cmd.op   = OP_STOP;
                      cmd.kind = K_DENIED;
                    end
                  end else begin
                    unsup = 1'b1;
                  end
                end
                PH_REX: begin
                  opc_nxt = code_byte;
                  imm_nxt = '0;
                  if (code_byte >= OPC_MOVI0 && code_byte <= OPC_MOVI7) begin
                    need_nxt  = 4'd8;
                    phase_nxt = PH_IMM;
                  end else begin
                    phase_nxt = PH_MODRM;
                  end
                end
                PH_MODRM: begin
                  modrm_nxt = code_byte;
                  cmd.dst   = code_byte[2:0];
                  cmd.src   = code_byte[5:3];
                  if (code_byte[7:6] != 2'b11) begin
                    unsup = 1'b1;
                  end else if (opc_r == OPC_MOVR) begin
                    done = 1'b1; cmd.op = OP_MOV;
                  end else if (opc_r == OPC_ADDR) begin
                    done = 1'b1; cmd.op = OP_ADD;
                  end else if (opc_r != OPC_MOVS || code_byte[5:3] != 3'd0) begin
                    unsup = 1'b1;
                  end else begin
                    need_nxt  = 4'd4;
                    phase_nxt = PH_IMM;
                  end
                end
                default: begin
                  imm_nxt  = imm_or;
                  need_nxt = need_eff - 4'd1;
                  if (need_eff == 4'd1) begin
                    done   = 1'b1;
                    cmd.op = OP_IMM;
                    if (total == 4'd4) begin
                      cmd.dst   = modrm_r[2:0];
                      cmd.value = {{32{imm_or[31]}}, imm_or[31:0]};
                    end else begin
                      cmd.dst   = opc_r[2:0];
                      cmd.value = imm_or;
                    end
                  end
                end
              endcase
              if (unsup) begin
                cmd_valid = 1'b1;
                cmd.op    = OP_STOP;
                cmd.kind  = K_UNSUP;
                running_nxt = 1'b0;
                phase_nxt = PH_FIRST;
                need_nxt  = '0;
              end else if (done) begin
                cmd_valid = 1'b1;
                cnt_nxt   = cnt_inc;
                cmd.count = cnt_inc;
                start_nxt = ofs_inc;
                phase_nxt = PH_FIRST;
                need_nxt  = '0;
                cmd.at_limit = (cnt_inc >= step_limit);
                if (cmd.op == OP_STOP) begin
                  cmd.addr = fault;
                  running_nxt = 1'b0;
                end else begin
                  cmd.addr = rip;
                  if (cmd.op == OP_RET || cmd.at_limit || is_last)
                    running_nxt = 1'b0;
                end
              end else if (is_last) begin
                cmd_valid = 1'b1;
                cmd.op    = OP_STOP;
                cmd.kind  = K_TRUNC;
                running_nxt = 1'b0;
                phase_nxt = PH_FIRST;
                need_nxt  = '0;
              end
            end
          end
        end
      endcase
    end
  end

  // decode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      phase_r   <= PH_FIRST;
      ofs_r     <= '0;
      start_r   <= '0;
      cnt_r     <= '0;
      need_r    <= '0;
    end else begin
      running_r <= running_nxt;
      phase_r   <= phase_nxt;
      ofs_r     <= ofs_nxt;
      start_r   <= start_nxt;
      cnt_r     <= cnt_nxt;
      need_r    <= need_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opc_r   <= '0;
      modrm_r <= '0;
      imm_r   <= '0;
    end else begin
      opc_r   <= opc_nxt;
      modrm_r <= modrm_nxt;
      imm_r   <= imm_nxt;
    end
  end

  // no decode progress while idle
  assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> phase_r == PH_FIRST)
    else $error("decode phase left first byte while idle");
  // step count only grows by one at a time or restarts
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != $past(cnt_r) |-> cnt_r == $past(cnt_r) + 32'd1 || cnt_r == '0)
    else $error("step count jumped");
  // a command appears only on an accepted beat
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid |-> fire)
    else $error("command without input beat");

endmodule

>>> src/x86de_queue.sv
// ----------------------------------------------------------------------------
// x86de_queue: small command queue between decoder and executor
// ----------------------------------------------------------------------------
module x86de_queue import x86de_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_data
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   fill_r, fill_nxt;
  logic              push, pop;

  assign wr_ready = (fill_r != QPTR_W'(0) + (QPTR_W+1)'(QDEPTH));
  assign rd_valid = (fill_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rp_r];

  // fill tracking
  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) fill_nxt = fill_r + 1'b1;
    else if (pop && !push) fill_nxt = fill_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      fill_r <= fill_nxt;
    end
  end

  // entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= (QPTR_W+1)'(QDEPTH))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == '0 |-> wp_r == rp_r)
    else $error("pointers disagree with empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> fill_r == $past(fill_r) + 1'b1)
    else $error("push lost");

endmodule

>>> src/x86de_back.sv
// ----------------------------------------------------------------------------
// x86de_back: executor
// runs commands on regfile, emits one or two results per non-write command
// ----------------------------------------------------------------------------
module x86de_back import x86de_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  logic [63:0] rf_r [NUM_REGS];
  logic        second_r, second_nxt;   // executed result done, tail pending
  logic        res_valid_r;
  res_t        res_r;
  logic        out_free;
  logic        two;
  logic        emit;
  logic [63:0] src_v, dst_v, new_v;
  res_t        r;

  assign out_free  = !res_valid_r || res_ready;
  assign src_v     = rf_r[cmd.src];
  assign dst_v     = rf_r[cmd.dst];
  assign two       = (cmd.op == OP_NOP || cmd.op == OP_SYS || cmd.op == OP_MOV ||
                      cmd.op == OP_ADD || cmd.op == OP_IMM) &&
                     (cmd.at_limit || cmd.last);
  assign emit      = cmd_valid && out_free && cmd.op != OP_WRITE;
  assign cmd_ready = cmd.op == OP_WRITE ? 1'b1 : (out_free && (!two || second_r));
  assign res_valid = res_valid_r;
  assign res       = res_r;

  // new register value
  always_comb begin
    case (cmd.op)
      OP_MOV:  new_v = src_v;
      OP_ADD:  new_v = dst_v + src_v;
      default: new_v = cmd.value;
    endcase
  end

  // result build
  always_comb begin
    r = '0;
    r.executed_count = cmd.count;
    r.address        = cmd.addr;
    second_nxt       = second_r;
    if (second_r) begin
      r.kind        = cmd.at_limit ? K_LIMIT : K_TRUNC;
      r.last_of_run = 1'b1;
    end else begin
      unique case (cmd.op)
        OP_RET: begin r.kind = K_DONE; r.last_of_run = 1'b1; end
        OP_STOP: begin r.kind = cmd.kind; r.last_of_run = 1'b1; end
        OP_READ: begin
          r.kind = K_READ; r.address = '0; r.dest_index = cmd.dst;
          r.dest_value = dst_v; r.last_of_run = 1'b1;
        end
        OP_MOV, OP_ADD, OP_IMM: begin
          r.kind = K_EXEC; r.wrote_register = 1'b1;
          r.dest_index = cmd.dst; r.dest_value = new_v; r.last_of_run = !two;
        end
        default: begin
          r.kind = K_EXEC; r.was_syscall = (cmd.op == OP_SYS);
          r.last_of_run = !two;
        end
      endcase
    end
    if (emit) second_nxt = two && !second_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else begin
      second_r <= second_nxt;
      if (emit) res_valid_r <= 1'b1;
      else if (res_ready) res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) res_r <= r;
  end

  // register file writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) rf_r[i] <= '0;
    end else if (cmd_valid && !second_r &&
                 (cmd.op == OP_WRITE || (emit && (cmd.op == OP_MOV ||
                  cmd.op == OP_ADD || cmd.op == OP_IMM)))) begin
      rf_r[cmd.dst] <= new_v;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> cmd_valid)
    else $error("tail pending without command");
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && !res_ready |=> res_valid_r && $stable(res_r))
    else $error("held result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    emit && second_r |-> cmd_ready)
    else $error("tail result did not retire command");

endmodule
